@@ hw/rtl/kste_pkg.sv @@
`default_nettype none

package kste_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SRC_W    = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [KEY_W-1:0] RESERVED_KEY = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEWEST = 2'd2,
    OP_LIST   = 2'd3
  } kste_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REPORTED  = 3'd4,
    ST_EMPTY     = 3'd5
  } kste_status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] tim;
  } kste_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic finish;
  } kste_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } kste_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/kste_ctrl.sv @@
`default_nettype none

module kste_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output kste_pkg::kste_cmd_t      cmd_o,
  input  wire kste_pkg::kste_sts_t sts_i
);

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        CS_IDLE: begin
          if (start_i) begin
            state_q <= CS_SCAN;
            busy_q  <= 1'b1;
          end
        end
        CS_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= CS_FINISH;
          end
        end
        CS_FINISH: begin
          state_q <= CS_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= CS_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign cmd_o.load   = start_i && !busy_q;
  assign cmd_o.finish = (state_q == CS_FINISH);

endmodule

`default_nettype wire

@@ hw/rtl/kste_dp.sv @@
`default_nettype none

module kste_dp #(
  parameter int unsigned Slots = kste_pkg::SLOTS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire kste_pkg::kste_cmd_t                 cmd_i,
  output kste_pkg::kste_sts_t                      sts_o,
  input  wire logic [kste_pkg::CMD_W-1:0]          command_i,
  input  wire logic [kste_pkg::KEY_W-1:0]          key_id_i,
  input  wire logic [kste_pkg::SRC_W-1:0]          source_code_i,
  input  wire logic [kste_pkg::TIME_W-1:0]         time_now_i,
  output logic                                     res_valid_o,
  output logic [kste_pkg::STATUS_W-1:0]            status_o,
  output logic [kste_pkg::SLOT_W-1:0]              slot_o,
  output logic [kste_pkg::KEY_W-1:0]               entry_id_o,
  output logic [kste_pkg::SRC_W-1:0]               entry_source_o,
  output logic [kste_pkg::TIME_W-1:0]              entry_time_o,
  output logic                                     evicted_o,
  output logic [kste_pkg::KEY_W-1:0]               evicted_id_o,
  output logic [kste_pkg::COUNT_W-1:0]             count_o,
  output logic                                     last_o
);

  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam logic [AW-1:0] LastAddr = AW'(Slots - 1);
  localparam logic [CW-1:0] SlotsCnt = CW'(Slots);

  // latched command
  kste_pkg::kste_op_e            op_q;
  kste_pkg::kste_entry_t         in_q;

  // entry memory and walk pipeline
  kste_pkg::kste_entry_t         mem [Slots];
  logic                          issue_q;
  logic [AW-1:0]                 scan_addr_q;
  logic                          rd_vld_q;
  logic                          rd_last_q;
  logic [AW-1:0]                 rd_idx_q;
  kste_pkg::kste_entry_t         rd_ent_q;

  logic [Slots-1:0]              valid_q, valid_d;
  logic [CW-1:0]                 cnt_q, cnt_d;

  // walk results
  logic                          hit_q;
  logic [AW-1:0]                 hit_idx_q;
  kste_pkg::kste_entry_t         hit_ent_q;
  logic                          free_q;
  logic [AW-1:0]                 free_idx_q;
  logic                          best_q;
  logic [AW-1:0]                 best_idx_q;
  kste_pkg::kste_entry_t         best_ent_q;
  logic [kste_pkg::KEY_W-1:0]    min_key_q;
  logic [AW-1:0]                 min_idx_q;

  // result word
  logic                          res_valid_q, res_valid_d;
  kste_pkg::kste_status_e        res_status_q, res_status_d;
  logic [AW-1:0]                 res_slot_q, res_slot_d;
  kste_pkg::kste_entry_t         res_ent_q, res_ent_d;
  logic                          res_ev_q, res_ev_d;
  logic [kste_pkg::KEY_W-1:0]    res_evid_q, res_evid_d;
  logic [CW-1:0]                 res_cnt_q, res_cnt_d;
  logic                          res_last_q, res_last_d;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;

  logic                          reserved;
  logic                          slot_used;
  logic                          match;
  logic [Slots-1:0]              above;
  logic                          tail_clear;
  logic [CW-1:0]                 cnt_drop;

  assign reserved   = (in_q.key == kste_pkg::RESERVED_KEY);
  assign slot_used  = valid_q[rd_idx_q];
  assign match      = rd_vld_q && slot_used && !reserved && (rd_ent_q.key == in_q.key);
  assign above      = valid_q >> rd_idx_q;
  assign tail_clear = (above[Slots-1:1] == '0);
  assign cnt_drop   = (cnt_q != '0) ? (cnt_q - CW'(1)) : cnt_q;

  assign sts_o.scan_done = rd_vld_q && rd_last_q;

  // command latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= kste_pkg::kste_op_e'(command_i);
      in_q.key <= key_id_i;
      in_q.src <= source_code_i;
      in_q.tim <= time_now_i;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_q;
    end
    rd_ent_q <= mem[scan_addr_q];
  end

  // walk address generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      rd_vld_q  <= issue_q;
      rd_last_q <= issue_q && (scan_addr_q == LastAddr);
      rd_idx_q  <= scan_addr_q;
      if (cmd_i.load) begin
        issue_q     <= 1'b1;
        scan_addr_q <= '0;
      end else if (issue_q) begin
        if (scan_addr_q == LastAddr) begin
          issue_q <= 1'b0;
        end else begin
          scan_addr_q <= scan_addr_q + AW'(1);
        end
      end
    end
  end

  // per-slot compare stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      best_q    <= 1'b0;
      min_key_q <= kste_pkg::RESERVED_KEY;
      min_idx_q <= '0;
    end else if (rd_vld_q) begin
      if (match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
        hit_ent_q <= rd_ent_q;
      end
      if (!slot_used && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      // newest: strictly above zero and above the best so far
      if (slot_used && (!best_q || (rd_ent_q.key > best_ent_q.key)) &&
          (rd_ent_q.key != '0)) begin
        best_q     <= 1'b1;
        best_idx_q <= rd_idx_q;
        best_ent_q <= rd_ent_q;
      end
      if (slot_used && (rd_ent_q.key < min_key_q)) begin
        min_key_q <= rd_ent_q.key;
        min_idx_q <= rd_idx_q;
      end
    end
  end

  // result and table update
  always_comb begin
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    wr_en        = 1'b0;
    wr_addr      = free_idx_q;
    res_valid_d  = 1'b0;
    res_status_d = kste_pkg::ST_NOT_FOUND;
    res_slot_d   = '0;
    res_ent_d    = '0;
    res_ev_d     = 1'b0;
    res_evid_d   = '0;
    res_cnt_d    = cnt_q;
    res_last_d   = 1'b1;

    if (rd_vld_q && slot_used && (op_q == kste_pkg::OP_LIST)) begin
      res_valid_d  = 1'b1;
      res_status_d = kste_pkg::ST_REPORTED;
      res_slot_d   = rd_idx_q;
      res_ent_d    = rd_ent_q;
      res_last_d   = tail_clear;
    end

    if (cmd_i.finish) begin
      case (op_q)
        kste_pkg::OP_ADD: begin
          res_valid_d = 1'b1;
          if (reserved) begin
            res_status_d = kste_pkg::ST_NOT_FOUND;
          end else if (hit_q) begin
            res_status_d = kste_pkg::ST_DUPLICATE;
            res_slot_d   = hit_idx_q;
            res_ent_d    = hit_ent_q;
          end else begin
            wr_en        = 1'b1;
            res_status_d = kste_pkg::ST_INSERTED;
            res_ent_d    = in_q;
            if (free_q) begin
              wr_addr = free_idx_q;
              cnt_d   = (cnt_q < SlotsCnt) ? (cnt_q + CW'(1)) : cnt_q;
            end else begin
              // table full: the smallest key gives way
              wr_addr    = min_idx_q;
              res_ev_d   = 1'b1;
              res_evid_d = min_key_q;
              cnt_d      = (cnt_drop < SlotsCnt) ? (cnt_drop + CW'(1)) : cnt_drop;
            end
            res_slot_d       = wr_addr;
            valid_d[wr_addr] = 1'b1;
            res_cnt_d        = cnt_d;
          end
        end
        kste_pkg::OP_REMOVE: begin
          res_valid_d = 1'b1;
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            cnt_d              = cnt_drop;
            res_cnt_d          = cnt_drop;
            res_status_d       = kste_pkg::ST_REMOVED;
            res_slot_d         = hit_idx_q;
            res_ent_d          = hit_ent_q;
          end else begin
            res_status_d = kste_pkg::ST_NOT_FOUND;
          end
        end
        kste_pkg::OP_NEWEST: begin
          res_valid_d = 1'b1;
          if (best_q) begin
            res_status_d = kste_pkg::ST_REPORTED;
            res_slot_d   = best_idx_q;
            res_ent_d    = best_ent_q;
          end else begin
            res_status_d = kste_pkg::ST_EMPTY;
          end
        end
        kste_pkg::OP_LIST: begin
          if (valid_q == '0) begin
            res_valid_d  = 1'b1;
            res_status_d = kste_pkg::ST_EMPTY;
          end
        end
        default: begin
          res_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_ent_q    <= res_ent_d;
      res_ev_q     <= res_ev_d;
      res_evid_q   <= res_evid_d;
      res_cnt_q    <= res_cnt_d;
      res_last_q   <= res_last_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign status_o       = res_status_q;
  assign slot_o         = kste_pkg::SLOT_W'(res_slot_q);
  assign entry_id_o     = res_ent_q.key;
  assign entry_source_o = res_ent_q.src;
  assign entry_time_o   = res_ent_q.tim;
  assign evicted_o      = res_ev_q;
  assign evicted_id_o   = res_evid_q;
  assign count_o        = kste_pkg::COUNT_W'(res_cnt_q);
  assign last_o         = res_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/keyed_slot_table_evict_min_unit.sv @@
// keyed slot table with smallest-key eviction. a command word is taken on a
// clock edge where start_i is high and busy_o is low; every result word is
// shown for exactly one cycle with res_valid_o high and must be taken then,
// since there is no way to hold results off. add, remove and newest give one
// word each; list gives one word per valid slot in slot order (last_o on the
// final one) or a single table-empty word. every command keeps the block
// busy from acceptance until the next command can be taken: the command
// walks the entry memory one slot per cycle through its single registered
// read port, then the table update is applied. add, remove, newest and an
// empty list show their word once that update is applied, and busy_o drops
// while that word is shown, so the next command may be given in that cycle.
// list words stream out during the walk, each registered once more after
// the slot read.

`default_nettype none

module keyed_slot_table_evict_min_unit #(
  parameter int unsigned Slots = kste_pkg::SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command word
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [kste_pkg::CMD_W-1:0]  command_i,
  input  wire logic [kste_pkg::KEY_W-1:0]  key_id_i,
  input  wire logic [kste_pkg::SRC_W-1:0]  source_code_i,
  input  wire logic [kste_pkg::TIME_W-1:0] time_now_i,
  // result word
  output logic                             res_valid_o,
  output logic [kste_pkg::STATUS_W-1:0]    status_o,
  output logic [kste_pkg::SLOT_W-1:0]      slot_o,
  output logic [kste_pkg::KEY_W-1:0]       entry_id_o,
  output logic [kste_pkg::SRC_W-1:0]       entry_source_o,
  output logic [kste_pkg::TIME_W-1:0]      entry_time_o,
  output logic                             evicted_o,
  output logic [kste_pkg::KEY_W-1:0]       evicted_id_o,
  output logic [kste_pkg::COUNT_W-1:0]     count_o,
  output logic                             last_o
);

  // controller to datapath: latch the command, apply the update
  kste_pkg::kste_cmd_t cmd;
  // datapath to controller: last slot of the walk compared
  kste_pkg::kste_sts_t sts;

  kste_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // entry memory, valid bits, entry count, walk compare and result register
  kste_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .command_i      (command_i),
    .key_id_i       (key_id_i),
    .source_code_i  (source_code_i),
    .time_now_i     (time_now_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entry_id_o     (entry_id_o),
    .entry_source_o (entry_source_o),
    .entry_time_o   (entry_time_o),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .count_o        (count_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

@@ dv/kste_table_checker.sv @@
`default_nettype none

module kste_table_checker
  import kste_pkg::*;
#(
  parameter int unsigned Slots = SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_o,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [KEY_W-1:0]    key_id_i,
  input  wire logic [SRC_W-1:0]    source_code_i,
  input  wire logic [TIME_W-1:0]   time_now_i,
  input  wire logic                res_valid_o,
  input  wire logic [STATUS_W-1:0] status_o,
  input  wire logic [SLOT_W-1:0]   slot_o,
  input  wire logic [KEY_W-1:0]    entry_id_o,
  input  wire logic [SRC_W-1:0]    entry_source_o,
  input  wire logic [TIME_W-1:0]   entry_time_o,
  input  wire logic                evicted_o,
  input  wire logic [KEY_W-1:0]    evicted_id_o,
  input  wire logic [COUNT_W-1:0]  count_o,
  input  wire logic                last_o,
  output int                       fail_count_o,
  output int                       pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kste_status_e        status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    id;
    logic [SRC_W-1:0]    src;
    logic [TIME_W-1:0]   tim;
    logic                ev;
    logic [KEY_W-1:0]    ev_id;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } table_word_t;

  // shadow copy of the table
  logic              shadow_valid [Slots];
  logic [KEY_W-1:0]  shadow_key   [Slots];
  logic [SRC_W-1:0]  shadow_src   [Slots];
  logic [TIME_W-1:0] shadow_time  [Slots];
  int                shadow_count;

  table_word_t expected_words_q[$];
  int          mismatch_count = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = expected_words_q.size();

  task automatic push_word(kste_status_e st, int slot, logic [KEY_W-1:0] id,
                           logic [SRC_W-1:0] src, logic [TIME_W-1:0] tim, logic ev,
                           logic [KEY_W-1:0] ev_id, logic last);
    table_word_t w;
    w.status = st;
    w.slot   = SLOT_W'(slot);
    w.id     = id;
    w.src    = src;
    w.tim    = tim;
    w.ev     = ev;
    w.ev_id  = ev_id;
    w.count  = COUNT_W'(shadow_count);
    w.last   = last;
    expected_words_q.push_back(w);
  endtask

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic predict_table(kste_op_e op, logic [KEY_W-1:0] key,
                               logic [SRC_W-1:0] src, logic [TIME_W-1:0] tim);
    int               hit;
    int               free_slot;
    int               min_slot;
    int               total;
    int               n;
    logic [KEY_W-1:0] min_key;
    logic [KEY_W-1:0] best_key;
    logic             ev;
    logic [KEY_W-1:0] ev_id;
    hit       = -1;
    free_slot = -1;
    ev        = 1'b0;
    ev_id     = '0;
    case (op)
      OP_ADD: begin
        if (key == RESERVED_KEY) begin
          push_word(ST_NOT_FOUND, 0, '0, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          hit = find_slot(key);
          if (hit >= 0) begin
            push_word(ST_DUPLICATE, hit, shadow_key[hit], shadow_src[hit],
                      shadow_time[hit], 1'b0, '0, 1'b1);
          end else begin
            for (int i = 0; i < Slots; i++) begin
              if (!shadow_valid[i] && free_slot < 0) free_slot = i;
            end
            // full table: smallest key goes first
            if (free_slot < 0) begin
              min_slot = 0;
              min_key  = RESERVED_KEY;
              for (int i = 0; i < Slots; i++) begin
                if (shadow_valid[i] && shadow_key[i] < min_key) begin
                  min_key  = shadow_key[i];
                  min_slot = i;
                end
              end
              ev    = 1'b1;
              ev_id = shadow_key[min_slot];
              shadow_valid[min_slot] = 1'b0;
              if (shadow_count > 0) shadow_count--;
              free_slot = min_slot;
            end
            shadow_valid[free_slot] = 1'b1;
            shadow_key[free_slot]   = key;
            shadow_src[free_slot]   = src;
            shadow_time[free_slot]  = tim;
            if (shadow_count < Slots) shadow_count++;
            push_word(ST_INSERTED, free_slot, key, src, tim, ev, ev_id, 1'b1);
          end
        end
      end
      OP_REMOVE: begin
        hit = (key == RESERVED_KEY) ? -1 : find_slot(key);
        if (hit < 0) begin
          push_word(ST_NOT_FOUND, 0, '0, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          shadow_valid[hit] = 1'b0;
          if (shadow_count > 0) shadow_count--;
          push_word(ST_REMOVED, hit, shadow_key[hit], shadow_src[hit],
                    shadow_time[hit], 1'b0, '0, 1'b1);
        end
      end
      OP_NEWEST: begin
        // key zero never wins
        best_key = '0;
        for (int i = 0; i < Slots; i++) begin
          if (shadow_valid[i] && shadow_key[i] > best_key) begin
            best_key = shadow_key[i];
            hit      = i;
          end
        end
        if (hit < 0) begin
          push_word(ST_EMPTY, 0, '0, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          push_word(ST_REPORTED, hit, shadow_key[hit], shadow_src[hit],
                    shadow_time[hit], 1'b0, '0, 1'b1);
        end
      end
      default: begin
        total = 0;
        n     = 0;
        for (int i = 0; i < Slots; i++) begin
          if (shadow_valid[i]) total++;
        end
        if (total == 0) begin
          push_word(ST_EMPTY, 0, '0, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (shadow_valid[i]) begin
              n++;
              push_word(ST_REPORTED, i, shadow_key[i], shadow_src[i], shadow_time[i],
                        1'b0, '0, (n == total));
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i]   = '0;
        shadow_src[i]   = '0;
        shadow_time[i]  = '0;
      end
      shadow_count = 0;
      expected_words_q.delete();
    end else begin
      if (res_valid_o) begin
        if (expected_words_q.size() == 0) begin
          $error("result word with no expectation: status %0h slot %0h id %0h",
                 status_o, slot_o, entry_id_o);
          mismatch_count++;
        end else begin
          w = expected_words_q.pop_front();
          check_field("status", 32'(w.status), 32'(status_o));
          check_field("slot", 32'(w.slot), 32'(slot_o));
          check_field("entry_id", w.id, entry_id_o);
          check_field("entry_source", 32'(w.src), 32'(entry_source_o));
          check_field("entry_time", w.tim, entry_time_o);
          check_field("evicted", 32'(w.ev), 32'(evicted_o));
          check_field("evicted_id", w.ev_id, evicted_id_o);
          check_field("count", 32'(w.count), 32'(count_o));
          check_field("last", 32'(w.last), 32'(last_o));
        end
      end
      if (start_i && !busy_o) begin
        predict_table(kste_op_e'(command_i), key_id_i, source_code_i, time_now_i);
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_keyed_slot_table_evict_min_unit.sv @@
`default_nettype none

module tb_keyed_slot_table_evict_min_unit;

  import kste_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots      = SLOTS_DEF;
  localparam int unsigned CmdCycles  = Slots + 3;
  localparam int unsigned IdlePct    = 28;
  localparam int unsigned RandItems  = 220;
  localparam int unsigned PoolSize   = 24;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // command word into the block
  logic                start_i       = 1'b0;
  logic [CMD_W-1:0]    command_i     = OP_ADD;
  logic [KEY_W-1:0]    key_id_i      = '0;
  logic [SRC_W-1:0]    source_code_i = '0;
  logic [TIME_W-1:0]   time_now_i    = '0;

  // result word out of the block
  logic                busy_o;
  logic                res_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [KEY_W-1:0]    entry_id_o;
  logic [SRC_W-1:0]    entry_source_o;
  logic [TIME_W-1:0]   entry_time_o;
  logic                evicted_o;
  logic [KEY_W-1:0]    evicted_id_o;
  logic [COUNT_W-1:0]  count_o;
  logic                last_o;

  int fail_count;
  int pending_words;

  // when set, the sender never idles between command words
  bit no_idle = 1'b0;

  // keys drawn often so that duplicates, hits and evictions happen
  logic [KEY_W-1:0] key_pool [PoolSize];

  keyed_slot_table_evict_min_unit #(
    .Slots(Slots)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .key_id_i       (key_id_i),
    .source_code_i  (source_code_i),
    .time_now_i     (time_now_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entry_id_o     (entry_id_o),
    .entry_source_o (entry_source_o),
    .entry_time_o   (entry_time_o),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .count_o        (count_o),
    .last_o         (last_o)
  );

  kste_table_checker #(
    .Slots(Slots)
  ) u_table_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .key_id_i       (key_id_i),
    .source_code_i  (source_code_i),
    .time_now_i     (time_now_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entry_id_o     (entry_id_o),
    .entry_source_o (entry_source_o),
    .entry_time_o   (entry_time_o),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .count_o        (count_o),
    .last_o         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_words)
  );

  // present one command word and hold it until the block takes it.
  // entered between a rising and a falling edge, returns just after the
  // accepting rising edge with start_i still high
  task automatic issue_word(kste_op_e op, logic [KEY_W-1:0] key,
                            logic [SRC_W-1:0] src, logic [TIME_W-1:0] tim);
    @(negedge clk_i);
    // random idle cycles with junk on the payload
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      start_i       <= 1'b0;
      command_i     <= CMD_W'($urandom_range(3));
      key_id_i      <= $urandom;
      source_code_i <= SRC_W'($urandom_range(15));
      time_now_i    <= $urandom;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    command_i     <= op;
    key_id_i      <= key;
    source_code_i <= src;
    time_now_i    <= tim;
    // accept happens on a rising edge with busy low
    do @(posedge clk_i); while (busy_o);
  endtask

  // stop sending and let every expected word come back
  task automatic drain_table;
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (CmdCycles) @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return RESERVED_KEY;
    if (r < 78) return key_pool[$urandom_range(PoolSize - 1)];
    return $urandom;
  endfunction

  // command mix shifts with the phase of the random part
  function automatic kste_op_e pick_op(int phase);
    int unsigned r;
    r = $urandom_range(99);
    case (phase)
      0: return (r < 70) ? OP_ADD : (r < 80) ? OP_REMOVE : (r < 90) ? OP_NEWEST : OP_LIST;
      1: return (r < 20) ? OP_ADD : (r < 75) ? OP_REMOVE : (r < 88) ? OP_NEWEST : OP_LIST;
      default: return (r < 45) ? OP_ADD : (r < 70) ? OP_REMOVE : (r < 85) ? OP_NEWEST : OP_LIST;
    endcase
  endfunction

  // stimulus
  initial begin
    int phase;
    // pool with both key extremes and some small keys
    key_pool[0] = '0;
    key_pool[1] = 32'hFFFF_FFFE;
    for (int i = 2; i < 6; i++) key_pool[i] = KEY_W'(i);
    for (int i = 6; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // empty table: list, newest and remove all find nothing
    issue_word(OP_LIST, '0, '0, '0);
    issue_word(OP_NEWEST, '0, '0, '0);
    issue_word(OP_REMOVE, 32'h0000_0001, '0, '0);
    // reserved key is neither stored nor matched
    issue_word(OP_ADD, RESERVED_KEY, 4'hF, 32'hFFFF_FFFF);
    issue_word(OP_REMOVE, RESERVED_KEY, '0, '0);
    // key zero is stored and listed but never the newest
    issue_word(OP_ADD, '0, 4'h0, 32'h0000_0000);
    issue_word(OP_NEWEST, '0, '0, '0);
    issue_word(OP_LIST, '0, '0, '0);
    // largest legal key, then a duplicate with other payload
    issue_word(OP_ADD, 32'hFFFF_FFFE, 4'hF, 32'hFFFF_FFFF);
    issue_word(OP_ADD, 32'hFFFF_FFFE, 4'h5, 32'h1234_5678);
    issue_word(OP_NEWEST, '0, '0, '0);
    // remove reports the old entry, a second remove finds nothing
    issue_word(OP_REMOVE, 32'hFFFF_FFFE, '0, '0);
    issue_word(OP_REMOVE, 32'hFFFF_FFFE, '0, '0);
    // fill every slot, count reaches the slot total
    for (int i = 1; i < Slots; i++) begin
      issue_word(OP_ADD, KEY_W'(32'h8000_0000 + i), SRC_W'(i), $urandom);
    end
    // full table: next add evicts the smallest key (zero)
    issue_word(OP_ADD, 32'hA5A5_5A5A, 4'hA, 32'h5A5A_A5A5);
    issue_word(OP_LIST, '0, '0, '0);
    issue_word(OP_NEWEST, '0, '0, '0);
    // sender holds off until the table has answered everything
    drain_table();

    // ---- random part ----
    for (int n = 0; n < RandItems; n++) begin
      phase = (n < 100) ? 0 : (n < 175) ? 1 : 2;
      // a stretch with no idling at all
      no_idle = (n >= 100 && n < 150);
      if (n == 100 || n == 175) drain_table();
      issue_word(pick_op(phase), pick_key(), SRC_W'($urandom_range(15)), $urandom);
    end

    // ---- end of run ----
    drain_table();
    if (fail_count == 0 && pending_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard limit on run time, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
